FILE: hdl/triggered_capture_buffer_assert.svh
// Assertion macros used by the capture buffer checker.
`ifndef TRIGGERED_CAPTURE_BUFFER_ASSERT_SVH
`define TRIGGERED_CAPTURE_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define TCB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define TCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tcb_pkg.sv
// Shared constants, codes, types and helper functions of the capture buffer.
package tcb_pkg;

    localparam int DEPTH         = 256;
    localparam int POST_SAMPLES  = 128;
    localparam int SIGNALS       = 56;
    localparam int EVENT_LIST_ID = 1;

    localparam int LANES      = 7;
    localparam int LANE_W     = 3;
    localparam int GRP_W      = 3;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int PC_W       = $clog2(POST_SAMPLES + 1);
    localparam int BANK_AW    = IDX_W + GRP_W;
    localparam int BANK_DEPTH = DEPTH * (1 << GRP_W);
    localparam int WIDTH_W    = 7;
    localparam int POS_W      = 6;
    localparam int ELEM_W     = 10;
    localparam int LIST_W     = 8;
    localparam int DATA_W     = 56;

    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_CAPTURE = 3'd1;
    localparam logic [2:0] REQ_TRIGGER = 3'd2;
    localparam logic [2:0] REQ_READ    = 3'd3;
    localparam logic [2:0] REQ_STOP    = 3'd4;

    typedef enum logic [2:0] {
        MODE_INIT      = 3'd0,
        MODE_RUNNING   = 3'd1,
        MODE_TRIGGERED = 3'd2,
        MODE_FINISHED  = 3'd3,
        MODE_STOPPED   = 3'd4,
        MODE_UPLOADING = 3'd5,
        MODE_STORED    = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic read_hit;
    } status_t;

    // Quotient by 7 for values below 64: multiply by 37/256.
    function automatic logic [3:0] div7(input logic [5:0] x);
        logic [11:0] p;
        p = 12'(x) * 12'd37;
        return p[11:8];
    endfunction

    function automatic logic [2:0] mod7(input logic [5:0] x);
        logic [5:0] t;
        t = x - 6'(div7(x)) * 6'd7;
        return t[2:0];
    endfunction

endpackage

FILE: hdl/triggered_capture_buffer.sv
// A word is latched on accept and committed from ST_EXEC, or from ST_READ for a read that returns data;
// the result is registered on commit, which waits for a free output slot. One word is in flight,
// and the bank read plus the registered byte gather add the ST_READ state.
// A new word is taken while the previous result still waits on m_ready.
// Reset (aresetn low, synchronous) clears the controller, the result valid and the capture
// state; sample store contents are not cleared and no clearing pass runs.
module triggered_capture_buffer
    import tcb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [LIST_W-1:0] s_list_id,
    input  logic [ELEM_W-1:0] s_element_index,
    input  logic [2:0]        s_odt_last_index,
    input  logic [7:0]        s_sample_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_accepted,
    output logic [DATA_W-1:0] m_odt_data,
    output logic [2:0]        m_mode,
    output logic              m_buffer_full
);

    cmd_t    cmd;
    status_t status;

    tcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcb_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_req_type       (s_req_type),
        .s_list_id        (s_list_id),
        .s_element_index  (s_element_index),
        .s_odt_last_index (s_odt_last_index),
        .s_sample_byte    (s_sample_byte),
        .m_accepted       (m_accepted),
        .m_odt_data       (m_odt_data),
        .m_mode           (m_mode),
        .m_buffer_full    (m_buffer_full)
    );

endmodule

FILE: hdl/tcb_ctrl.sv
// Controller state machine: sequences accept, bank read and commit of each word.
module tcb_ctrl
    import tcb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.read_hit) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_READ;
                end else if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                // bank data is registered and held; wait for the output slot
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

FILE: hdl/tcb_datapath.sv
// Datapath: item registers, capture state, seven-bank sample store and result registers.
module tcb_datapath
    import tcb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [2:0]        s_req_type,
    input  logic [LIST_W-1:0] s_list_id,
    input  logic [ELEM_W-1:0] s_element_index,
    input  logic [2:0]        s_odt_last_index,
    input  logic [7:0]        s_sample_byte,
    output logic              m_accepted,
    output logic [DATA_W-1:0] m_odt_data,
    output logic [2:0]        m_mode,
    output logic              m_buffer_full
);

    // latched word
    logic [2:0]        req_reg;
    logic              ev_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [2:0]        odt_reg;
    logic [7:0]        byte_reg;

    // capture state
    logic [IDX_W-1:0]   write_index_reg, write_index_next;
    logic [IDX_W-1:0]   oldest_index_reg, oldest_index_next;
    logic [PC_W-1:0]    post_count_reg, post_count_next;
    logic               full_reg, full_next;
    mode_t              mode_reg, mode_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [ELEM_W-1:0]  list_base_reg, list_base_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LANE_W-1:0]  lane_reg, lane_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;

    // read path
    logic [ELEM_W-1:0]  off;
    logic [3:0]         off_q;
    logic [2:0]         off_r;
    logic [ELEM_W-1:0]  off_reg;
    logic [2:0]         off_r_reg;
    wire  [DATA_W-1:0]  bank_q;
    logic [DATA_W-1:0]  gather;

    logic               wr_en;
    logic [BANK_AW-1:0] wr_addr;

    // result registers
    logic              m_accepted_reg;
    logic [DATA_W-1:0] m_odt_data_reg;
    mode_t             m_mode_reg;
    logic              m_buffer_full_reg;

    assign status.read_hit = (req_reg == REQ_READ) && ev_reg && full_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_reg  <= s_req_type;
            ev_reg   <= (s_list_id == LIST_W'(EVENT_LIST_ID));
            elem_reg <= s_element_index;
            odt_reg  <= s_odt_last_index;
            byte_reg <= s_sample_byte;
        end
    end

    assign off   = elem_reg - list_base_reg;
    assign off_q = div7(off[5:0]);
    assign off_r = mod7(off[5:0]);

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            off_reg   <= off;
            off_r_reg <= off_r;
        end
    end

    // byte p of a row lives in bank p mod 7 at group p div 7
    assign wr_en = cmd.commit && (req_reg == REQ_CAPTURE) && (width_reg != '0) && !full_reg
                   && (pos_reg < POS_W'(SIGNALS));
    assign wr_addr = {write_index_reg, grp_reg};

    genvar b;
    for (b = 0; b < LANES; b++) begin : g_bank
        logic [7:0]       mem [BANK_DEPTH];
        logic [7:0]       rdata_reg;
        logic [GRP_W-1:0] grp_sel;

        // banks below the start lane hold the next group
        assign grp_sel = GRP_W'(off_q + ((LANE_W'(b) < off_r) ? 4'd1 : 4'd0));

        always_ff @(posedge aclk) begin
            if (wr_en && (lane_reg == LANE_W'(b))) begin
                mem[wr_addr] <= byte_reg;
            end
            if (cmd.rd_en) begin
                rdata_reg <= mem[{oldest_index_reg, grp_sel}];
            end
        end

        assign bank_q[b*8 +: 8] = rdata_reg;
    end

    // rotate bank outputs back into byte order and zero bytes past the width
    always_comb begin
        logic [WIDTH_W-1:0] lim;
        logic [3:0]         s;
        logic [2:0]         bidx;
        logic [ELEM_W:0]    pos;
        lim    = (width_reg < WIDTH_W'(SIGNALS)) ? width_reg : WIDTH_W'(SIGNALS);
        gather = '0;
        for (int k = 0; k < LANES; k++) begin
            s    = {1'b0, off_r_reg} + 4'(k);
            bidx = (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
            pos  = {1'b0, off_reg} + (ELEM_W+1)'(k);
            if (pos < (ELEM_W+1)'(lim)) begin
                gather[k*8 +: 8] = bank_q[{bidx, 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        logic [IDX_W-1:0]   wi_inc;
        logic [IDX_W-1:0]   oi_inc;
        logic [PC_W-1:0]    pc_inc;
        logic [WIDTH_W-1:0] pos_inc;
        logic [3:0]         groups;

        write_index_next  = write_index_reg;
        oldest_index_next = oldest_index_reg;
        post_count_next   = post_count_reg;
        full_next         = full_reg;
        mode_next         = mode_reg;
        width_next        = width_reg;
        list_base_next    = list_base_reg;
        pos_next          = pos_reg;
        lane_next         = lane_reg;
        grp_next          = grp_reg;

        wi_inc  = (write_index_reg == IDX_W'(DEPTH - 1)) ? '0 : write_index_reg + 1'b1;
        oi_inc  = (oldest_index_reg == IDX_W'(DEPTH - 1)) ? '0 : oldest_index_reg + 1'b1;
        pc_inc  = post_count_reg + 1'b1;
        pos_inc = {1'b0, pos_reg} + 1'b1;
        groups  = {1'b0, odt_reg} + 4'd1;

        unique case (req_reg)
            REQ_START: begin
                if (ev_reg) begin
                    list_base_next = elem_reg;
                    width_next     = 7'({3'b000, groups}) * 7'd7;
                    pos_next       = '0;
                    lane_next      = '0;
                    grp_next       = '0;
                    if (mode_reg == MODE_STOPPED || mode_reg == MODE_INIT) begin
                        mode_next = MODE_RUNNING;
                    end
                end
            end
            REQ_CAPTURE: begin
                if (width_reg != '0 && !full_reg) begin
                    if (pos_inc >= width_reg) begin
                        // sample done: advance the row, count up after a trigger
                        pos_next         = '0;
                        lane_next        = '0;
                        grp_next         = '0;
                        write_index_next = wi_inc;
                        if (post_count_reg < PC_W'(POST_SAMPLES)) begin
                            post_count_next = pc_inc;
                            if (pc_inc >= PC_W'(POST_SAMPLES)) begin
                                oldest_index_next = wi_inc;
                                write_index_next  = '0;
                                full_next         = 1'b1;
                                mode_next         = MODE_STORED;
                            end
                        end
                    end else begin
                        pos_next = pos_inc[POS_W-1:0];
                        if (lane_reg == LANE_W'(LANES - 1)) begin
                            lane_next = '0;
                            grp_next  = grp_reg + 1'b1;
                        end else begin
                            lane_next = lane_reg + 1'b1;
                        end
                    end
                end
            end
            REQ_TRIGGER: begin
                if (!full_reg && (32'(write_index_reg) >= POST_SAMPLES)
                    && (mode_reg == MODE_RUNNING || mode_reg == MODE_FINISHED)) begin
                    post_count_next = '0;
                    mode_next       = MODE_TRIGGERED;
                end
            end
            REQ_READ: begin
                if (ev_reg && full_reg) begin
                    mode_next = MODE_UPLOADING;
                    if ({1'b0, off_reg} + (ELEM_W+1)'(7) >= (ELEM_W+1)'(width_reg)) begin
                        oldest_index_next = oi_inc;
                        if (write_index_reg == IDX_W'(DEPTH - 1)) begin
                            full_next        = 1'b0;
                            write_index_next = '0;
                            mode_next        = MODE_FINISHED;
                        end else begin
                            write_index_next = write_index_reg + 1'b1;
                        end
                    end
                end
            end
            REQ_STOP: begin
                if (ev_reg) begin
                    width_next = '0;
                    pos_next   = '0;
                    lane_next  = '0;
                    grp_next   = '0;
                    full_next  = 1'b0;
                    mode_next  = MODE_STOPPED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_index_reg  <= '0;
            oldest_index_reg <= '0;
            post_count_reg   <= PC_W'(POST_SAMPLES);
            full_reg         <= 1'b0;
            mode_reg         <= MODE_INIT;
            width_reg        <= '0;
            list_base_reg    <= '0;
            pos_reg          <= '0;
            lane_reg         <= '0;
            grp_reg          <= '0;
        end else if (cmd.commit) begin
            write_index_reg  <= write_index_next;
            oldest_index_reg <= oldest_index_next;
            post_count_reg   <= post_count_next;
            full_reg         <= full_next;
            mode_reg         <= mode_next;
            width_reg        <= width_next;
            list_base_reg    <= list_base_next;
            pos_reg          <= pos_next;
            lane_reg         <= lane_next;
            grp_reg          <= grp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_accepted_reg    <= status.read_hit;
            m_odt_data_reg    <= status.read_hit ? gather : '0;
            m_mode_reg        <= mode_next;
            m_buffer_full_reg <= full_next;
        end
    end

    assign m_accepted    = m_accepted_reg;
    assign m_odt_data    = m_odt_data_reg;
    assign m_mode        = m_mode_reg;
    assign m_buffer_full = m_buffer_full_reg;

endmodule

FILE: hdl/tcb_checker.sv
// Port-level checker for the capture buffer and its bind to the top level.
`include "triggered_capture_buffer_assert.svh"

module tcb_checker
    import tcb_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_accepted,
    input logic [DATA_W-1:0] m_odt_data,
    input logic [2:0]        m_mode,
    input logic              m_buffer_full
);

    // stalled result word must hold
    `TCB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_odt_data) && $stable(m_mode) && $stable(m_accepted) && $stable(m_buffer_full), "result word changed while stalled")

    `TCB_ASSERT_IMP(a_data_zero, m_valid && !m_accepted, m_odt_data == '0, "data nonzero on a word without read data")

    // a read that returns data leaves the record uploading or finished
    `TCB_ASSERT_IMP(a_read_mode, m_valid && m_accepted, m_mode == MODE_UPLOADING || m_mode == MODE_FINISHED, "read data with wrong mode")

    // frozen record only shows while stored or uploading
    `TCB_ASSERT_IMP(a_full_mode, m_valid && m_buffer_full, m_mode == MODE_STORED || m_mode == MODE_UPLOADING, "buffer full with wrong mode")

endmodule

bind triggered_capture_buffer tcb_checker u_tcb_checker (.*);
